/* rtl/bscu_pkg.sv */
// Shared constants and register index codes for the barometric compensation unit.
package bscu_pkg;

	localparam int DATAPATH_WIDTH_DEF = 64;
	localparam int MW = 64;
	localparam int RAW_W = 24;
	localparam int TEMP_W = 15;
	localparam int PRESS_W = 24;
	localparam int CFG_W = 48;
	localparam int CFG_IDX_W = 2;
	localparam int TEMP_MIN = -4000;
	localparam int TEMP_MAX = 8500;
	localparam int PRESS_MAX = 16777215;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP = 2'd0,
		CFG_PRESS_A = 2'd1,
		CFG_PRESS_B = 2'd2,
		CFG_PRESS_C = 2'd3
	} cfg_index_t;

endpackage

/* rtl/bscu_if.sv */
// Handshake channels for raw sample words and compensated result words.
interface bscu_sample_if import bscu_pkg::*; ;
	logic valid;
	logic ready;
	logic [RAW_W-1:0] raw_temperature;
	logic [RAW_W-1:0] raw_pressure;
	modport source(output valid, raw_temperature, raw_pressure, input ready);
	modport sink(input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bscu_result_if import bscu_pkg::*; ;
	logic valid;
	logic ready;
	logic signed [TEMP_W-1:0] temperature_centi_c;
	logic [PRESS_W-1:0] pressure_centi_pa;
	logic out_of_range;
	modport source(output valid, temperature_centi_c, pressure_centi_pa, out_of_range,
		input ready);
	modport sink(input valid, temperature_centi_c, pressure_centi_pa, out_of_range,
		output ready);
endinterface

/* rtl/barometric_sensor_compensation_unit.sv */
// Barometric compensation top level: calibration registers and the polynomial pipeline.
// Throughput is one word per cycle; the whole pipeline advances together and holds
// while a finished result waits and the result side is not ready.
// Reset clears all calibration registers to zero and drops every pipeline valid bit.
module barometric_sensor_compensation_unit import bscu_pkg::*; #(
	parameter int DATAPATH_WIDTH = DATAPATH_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	bscu_sample_if.sink          sample,
	bscu_result_if.source        result
);
	localparam int W = DATAPATH_WIDTH;
	localparam int NS = 31;
	localparam logic signed [W-1:0] LIM = (W'(1) << (W - 1)) - W'(1);
	localparam logic signed [W:0] LIMX = (W + 1)'(LIM);
	localparam logic signed [MW-1:0] HUNDRED = MW'(100);
	localparam logic signed [MW-1:0] ONE = MW'(1);
	localparam logic signed [W-1:0] T_LO = W'(TEMP_MIN);
	localparam logic signed [W-1:0] T_HI = W'(TEMP_MAX);
	localparam logic signed [W-1:0] P_HI = W'(PRESS_MAX);

	function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] x,
		input logic signed [W-1:0] y);
		logic signed [W:0] s;
		s = $signed({x[W-1], x}) + $signed({y[W-1], y});
		if (s > LIMX)
			return LIM;
		else if (s < -LIMX)
			return -LIM;
		return s[W-1:0];
	endfunction

	logic [39:0] cal_temp_q;
	logic [47:0] cal_press_a_q, cal_press_b_q;
	logic [31:0] cal_press_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q <= '0;
			cal_press_a_q <= '0;
			cal_press_b_q <= '0;
			cal_press_c_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_TEMP: cal_temp_q <= cfg_wdata[39:0];
				CFG_PRESS_A: cal_press_a_q <= cfg_wdata;
				CFG_PRESS_B: cal_press_b_q <= cfg_wdata;
				CFG_PRESS_C: cal_press_c_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	logic [15:0] t1, t2c, p5, p6;
	logic signed [7:0] t3c, p3, p4, p7, p8, p10, p11;
	logic signed [15:0] p1, p2, p9;
	logic signed [16:0] p1m, p2m;

	assign t1 = cal_temp_q[15:0];
	assign t2c = cal_temp_q[31:16];
	assign t3c = cal_temp_q[39:32];
	assign p1 = cal_press_a_q[15:0];
	assign p2 = cal_press_a_q[31:16];
	assign p3 = cal_press_a_q[39:32];
	assign p4 = cal_press_a_q[47:40];
	assign p5 = cal_press_b_q[15:0];
	assign p6 = cal_press_b_q[31:16];
	assign p7 = cal_press_b_q[39:32];
	assign p8 = cal_press_b_q[47:40];
	assign p9 = cal_press_c_q[15:0];
	assign p10 = cal_press_c_q[23:16];
	assign p11 = cal_press_c_q[31:24];
	assign p1m = 17'(p1) - 17'sd16384;
	assign p2m = 17'(p2) - 17'sd16384;

	logic en;
	logic [NS:1] valid_q;

	assign en = !valid_q[NS] || result.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[NS-1:1], sample.valid};
		end
	end

	logic signed [24:0] d_s1;
	logic [RAW_W-1:0] rp_s1;
	logic signed [41:0] dt2_s2;
	logic signed [49:0] dd_s2;
	logic [47:0] rp2_s2;
	logic signed [32:0] prp_s2;
	logic signed [MW-1:0] num_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, t1, 8'b0});
			rp_s1 <= sample.raw_pressure;
			dt2_s2 <= d_s1 * $signed({1'b0, t2c});
			dd_s2 <= d_s1 * d_s1;
			rp2_s2 <= rp_s1 * rp_s1;
			prp_s2 <= p11 * $signed({1'b0, rp_s1});
			num_s3 <= (MW'(dt2_s2) <<< 18) + dd_s2 * t3c;
		end
	end

	logic signed [W-1:0] t_s7, t_s11, tsq_s11, tcu_s15, tc_s11;
	logic signed [W-1:0] o6_s11, o7_s15, o8_s19, k5_s11, k3_s15, k4_s19, c10_s11;

	bscu_mulsh #(.W(W), .S(24)) u_mul_t (.clk, .en, .a(num_s3), .b(ONE), .q(t_s7));
	bscu_mulsh #(.W(W), .S(24)) u_mul_tsq (.clk, .en, .a(MW'(t_s7)), .b(MW'(t_s7)),
		.q(tsq_s11));
	bscu_dly #(.WD(W), .N(4)) u_dly_t (.clk, .en, .d(t_s7), .q(t_s11));
	bscu_mulsh #(.W(W), .S(24)) u_mul_tcu (.clk, .en, .a(MW'(tsq_s11)), .b(MW'(t_s11)),
		.q(tcu_s15));
	bscu_mulsh #(.W(W), .S(24)) u_mul_tc (.clk, .en, .a(MW'(t_s7)), .b(HUNDRED),
		.q(tc_s11));
	bscu_mulsh #(.W(W), .S(6)) u_mul_o6 (.clk, .en, .a(MW'({1'b0, p6})), .b(MW'(t_s7)),
		.q(o6_s11));
	bscu_mulsh #(.W(W), .S(8)) u_mul_o7 (.clk, .en, .a(MW'(p7)), .b(MW'(tsq_s11)),
		.q(o7_s15));
	bscu_mulsh #(.W(W), .S(15)) u_mul_o8 (.clk, .en, .a(MW'(p8)), .b(MW'(tcu_s15)),
		.q(o8_s19));
	bscu_mulsh #(.W(W), .S(5)) u_mul_k5 (.clk, .en, .a(MW'(p2m)), .b(MW'(t_s7)),
		.q(k5_s11));
	bscu_mulsh #(.W(W), .S(8)) u_mul_k3 (.clk, .en, .a(MW'(p3)), .b(MW'(tsq_s11)),
		.q(k3_s15));
	bscu_mulsh #(.W(W), .S(13)) u_mul_k4 (.clk, .en, .a(MW'(p4)), .b(MW'(tcu_s15)),
		.q(k4_s19));
	bscu_mulsh #(.W(W), .S(0)) u_mul_c10 (.clk, .en, .a(MW'(p10)), .b(MW'(t_s7)),
		.q(c10_s11));

	logic signed [W-1:0] c_s12, o1a_s12, ka_s12;
	logic signed [TEMP_W-1:0] tcc_s12;
	logic tflag_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			c_s12 <= sadd(W'(p9) <<< 24, c10_s11);
			o1a_s12 <= sadd(W'({1'b0, p5}) << 27, o6_s11);
			ka_s12 <= sadd(W'(p1m) <<< 28, k5_s11);
			if (tc_s11 < T_LO) begin
				tcc_s12 <= TEMP_W'(TEMP_MIN);
				tflag_s12 <= 1'b1;
			end else if (tc_s11 > T_HI) begin
				tcc_s12 <= TEMP_W'(TEMP_MAX);
				tflag_s12 <= 1'b1;
			end else begin
				tcc_s12 <= tc_s11[TEMP_W-1:0];
				tflag_s12 <= 1'b0;
			end
		end
	end

	logic [47:0] rp2_s12;
	logic signed [32:0] prp_s12;
	logic signed [W-1:0] o3a_s16, o3b_s16, o3_s17;

	bscu_dly #(.WD(48), .N(10)) u_dly_rp2 (.clk, .en, .d(rp2_s2), .q(rp2_s12));
	bscu_dly #(.WD(33), .N(10)) u_dly_prp (.clk, .en, .d(prp_s2), .q(prp_s12));
	bscu_mulsh #(.W(W), .S(48)) u_mul_o3a (.clk, .en, .a(MW'(rp2_s12)), .b(MW'(c_s12)),
		.q(o3a_s16));
	bscu_mulsh #(.W(W), .S(41)) u_mul_o3b (.clk, .en, .a(MW'(rp2_s12)), .b(MW'(prp_s12)),
		.q(o3b_s16));

	logic signed [W-1:0] o1a_s15, ka_s15, o1b_s16, kb_s16, o1b_s19, kb_s19, o1_s20, k_s20;

	bscu_dly #(.WD(W), .N(3)) u_dly_o1a (.clk, .en, .d(o1a_s12), .q(o1a_s15));
	bscu_dly #(.WD(W), .N(3)) u_dly_ka (.clk, .en, .d(ka_s12), .q(ka_s15));
	bscu_dly #(.WD(W), .N(3)) u_dly_o1b (.clk, .en, .d(o1b_s16), .q(o1b_s19));
	bscu_dly #(.WD(W), .N(3)) u_dly_kb (.clk, .en, .d(kb_s16), .q(kb_s19));

	always_ff @(posedge clk) begin
		if (en) begin
			o1b_s16 <= sadd(o1a_s15, o7_s15);
			kb_s16 <= sadd(ka_s15, k3_s15);
			o3_s17 <= sadd(o3a_s16, o3b_s16);
			o1_s20 <= sadd(o1b_s19, o8_s19);
			k_s20 <= sadd(kb_s19, k4_s19);
		end
	end

	logic [RAW_W-1:0] rp_s20;
	logic signed [W-1:0] o2_s24, o1_s24, o3_s25, x_s25, pa_s26, pc_s30;

	bscu_dly #(.WD(RAW_W), .N(19)) u_dly_rp (.clk, .en, .d(rp_s1), .q(rp_s20));
	bscu_mulsh #(.W(W), .S(24)) u_mul_o2 (.clk, .en, .a(MW'(rp_s20)), .b(MW'(k_s20)),
		.q(o2_s24));
	bscu_dly #(.WD(W), .N(4)) u_dly_o1 (.clk, .en, .d(o1_s20), .q(o1_s24));
	bscu_dly #(.WD(W), .N(8)) u_dly_o3 (.clk, .en, .d(o3_s17), .q(o3_s25));

	always_ff @(posedge clk) begin
		if (en) begin
			x_s25 <= sadd(o1_s24, o2_s24);
			pa_s26 <= sadd(x_s25, o3_s25);
		end
	end

	bscu_mulsh #(.W(W), .S(24)) u_mul_pc (.clk, .en, .a(MW'(pa_s26)), .b(HUNDRED),
		.q(pc_s30));

	logic [TEMP_W:0] tq_s30;
	logic signed [TEMP_W-1:0] temp_s31;
	logic [PRESS_W-1:0] press_s31;
	logic flag_s31;

	bscu_dly #(.WD(TEMP_W + 1), .N(18)) u_dly_tc (.clk, .en, .d({tflag_s12, tcc_s12}),
		.q(tq_s30));

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s31 <= tq_s30[TEMP_W-1:0];
			if (pc_s30 < 0) begin
				press_s31 <= '0;
				flag_s31 <= 1'b1;
			end else if (pc_s30 > P_HI) begin
				press_s31 <= PRESS_W'(PRESS_MAX);
				flag_s31 <= 1'b1;
			end else begin
				press_s31 <= pc_s30[PRESS_W-1:0];
				flag_s31 <= tq_s30[TEMP_W];
			end
		end
	end

	assign result.valid = valid_q[NS];
	assign result.temperature_centi_c = temp_s31;
	assign result.pressure_centi_pa = press_s31;
	assign result.out_of_range = flag_s31;
endmodule

/* rtl/bscu_dly.sv */
// Stallable delay line that keeps operands aligned across the pipeline.
module bscu_dly #(
	parameter int WD = 8,
	parameter int N = 1
) (
	input  logic          clk,
	input  logic          en,
	input  logic [WD-1:0] d,
	output logic [WD-1:0] q
);
	logic [WD-1:0] line_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[N-1];
endmodule

/* rtl/bscu_mulsh.sv */
// Four-stage signed multiply with rounding shift and symmetric saturation.
module bscu_mulsh import bscu_pkg::*; #(
	parameter int W = DATAPATH_WIDTH_DEF,
	parameter int S = 0
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [MW-1:0] a,
	input  logic signed [MW-1:0] b,
	output logic signed [W-1:0]  q
);
	localparam int HW = MW / 2;
	localparam int PW = 2 * MW;
	localparam logic [PW-1:0] RND = (S > 0) ? (PW'(1) << ((S > 0) ? S - 1 : 0)) : PW'(0);
	localparam logic [W-1:0] LIM = (W'(1) << (W - 1)) - W'(1);
	localparam logic [PW-1:0] LIMP = PW'(LIM);

	logic neg_s1, neg_s2, neg_s3;
	logic [MW-1:0] ua_s1, ub_s1;
	logic [MW-1:0] pp00_s2, pp01_s2, pp10_s2, pp11_s2;
	logic [PW-1:0] sum_s3;
	logic [PW-1:0] sh;
	logic [W-1:0] qm;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[MW-1] ^ b[MW-1];
			ua_s1 <= a[MW-1] ? (~a + MW'(1)) : a;
			ub_s1 <= b[MW-1] ? (~b + MW'(1)) : b;
			neg_s2 <= neg_s1;
			pp00_s2 <= ua_s1[HW-1:0] * ub_s1[HW-1:0];
			pp01_s2 <= ua_s1[HW-1:0] * ub_s1[MW-1:HW];
			pp10_s2 <= ua_s1[MW-1:HW] * ub_s1[HW-1:0];
			pp11_s2 <= ua_s1[MW-1:HW] * ub_s1[MW-1:HW];
			neg_s3 <= neg_s2;
			sum_s3 <= PW'(pp00_s2) + (PW'(pp01_s2) << HW) + (PW'(pp10_s2) << HW)
				+ (PW'(pp11_s2) << MW) + RND;
			q <= neg_s3 ? (~qm + W'(1)) : qm;
		end
	end

	always_comb begin
		sh = sum_s3 >> S;
		qm = (sh > LIMP) ? LIM : sh[W-1:0];
	end
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the barometric compensation unit with a built-in predictor.
module tb_top;
	import bscu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic [PRESS_W-1:0] press;
		logic oor;
	} comp_word_t;

	localparam longint SAT_LIM = 64'sh7fff_ffff_ffff_ffff;
	localparam int STALL_LONG = 300;
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	bscu_sample_if sample_ch();
	bscu_result_if result_ch();

	barometric_sensor_compensation_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .sample(sample_ch), .result(result_ch)
	);

	logic [CFG_W-1:0] cal_shadow [4] = '{default: '0};
	logic [2*RAW_W-1:0] raw_pending_q [$];
	comp_word_t comp_expect_q [$];
	int errors = 0;
	bit quiet = 1'b0;
	int gap_cnt = 0;
	int stall_cnt = 0;
	int long_asked = 0;
	int long_served = 0;
	int idle_cycles = 0;

	always #10 clk = ~clk;

	function automatic longint mul_rnd(longint a, longint b, int unsigned s);
		bit neg;
		bit [63:0] ua;
		bit [63:0] ub;
		bit [127:0] prod;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? 64'(-a) : 64'(a);
		ub = (b < 0) ? 64'(-b) : 64'(b);
		prod = {64'd0, ua} * {64'd0, ub};
		if (s > 0) begin
			prod = prod + (128'd1 << (s - 1));
		end
		prod = prod >> s;
		if (prod > 128'(SAT_LIM)) begin
			prod = 128'(SAT_LIM);
		end
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	function automatic longint sat_add(longint a, longint b);
		if (b > 0 && a > SAT_LIM - b) begin
			return SAT_LIM;
		end
		if (b < 0 && a < -SAT_LIM - b) begin
			return -SAT_LIM;
		end
		return a + b;
	endfunction

	function automatic comp_word_t compensate(logic [RAW_W-1:0] raw_t, logic [RAW_W-1:0] raw_p);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
		longint rt, rp, d, num, t, tsq, tcu, tc, o1, k, o2, rp2, c, o3, pa, pc;
		bit flag;
		comp_word_t w;
		t1 = longint'({48'd0, cal_shadow[CFG_TEMP][15:0]});
		t2 = longint'({48'd0, cal_shadow[CFG_TEMP][31:16]});
		t3 = longint'($signed(cal_shadow[CFG_TEMP][39:32]));
		p1 = longint'($signed(cal_shadow[CFG_PRESS_A][15:0]));
		p2 = longint'($signed(cal_shadow[CFG_PRESS_A][31:16]));
		p3 = longint'($signed(cal_shadow[CFG_PRESS_A][39:32]));
		p4 = longint'($signed(cal_shadow[CFG_PRESS_A][47:40]));
		p5 = longint'({48'd0, cal_shadow[CFG_PRESS_B][15:0]});
		p6 = longint'({48'd0, cal_shadow[CFG_PRESS_B][31:16]});
		p7 = longint'($signed(cal_shadow[CFG_PRESS_B][39:32]));
		p8 = longint'($signed(cal_shadow[CFG_PRESS_B][47:40]));
		p9 = longint'($signed(cal_shadow[CFG_PRESS_C][15:0]));
		p10 = longint'($signed(cal_shadow[CFG_PRESS_C][23:16]));
		p11 = longint'($signed(cal_shadow[CFG_PRESS_C][31:24]));
		rt = longint'({40'd0, raw_t});
		rp = longint'({40'd0, raw_p});
		flag = 1'b0;
		d = rt - t1 * 256;
		num = d * t2 * 262144 + d * d * t3;
		t = mul_rnd(num, 1, 24);
		tsq = mul_rnd(t, t, 24);
		tcu = mul_rnd(tsq, t, 24);
		tc = mul_rnd(t, 100, 24);
		if (tc < TEMP_MIN) begin
			tc = TEMP_MIN;
			flag = 1'b1;
		end
		if (tc > TEMP_MAX) begin
			tc = TEMP_MAX;
			flag = 1'b1;
		end
		o1 = p5 * (64'sd1 <<< 27);
		o1 = sat_add(o1, mul_rnd(p6, t, 6));
		o1 = sat_add(o1, mul_rnd(p7, tsq, 8));
		o1 = sat_add(o1, mul_rnd(p8, tcu, 15));
		k = (p1 - 16384) * (64'sd1 <<< 28);
		k = sat_add(k, mul_rnd(p2 - 16384, t, 5));
		k = sat_add(k, mul_rnd(p3, tsq, 8));
		k = sat_add(k, mul_rnd(p4, tcu, 13));
		o2 = mul_rnd(rp, k, 24);
		rp2 = rp * rp;
		c = sat_add(p9 * (64'sd1 <<< 24), mul_rnd(p10, t, 0));
		o3 = sat_add(mul_rnd(rp2, c, 48), mul_rnd(rp2, p11 * rp, 41));
		pa = sat_add(sat_add(o1, o2), o3);
		pc = mul_rnd(pa, 100, 24);
		if (pc < 0) begin
			pc = 0;
			flag = 1'b1;
		end
		if (pc > PRESS_MAX) begin
			pc = PRESS_MAX;
			flag = 1'b1;
		end
		w.temp = tc[TEMP_W-1:0];
		w.press = pc[PRESS_W-1:0];
		w.oor = flag;
		return w;
	endfunction

	// Sample word driver with random bursts of idle cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.raw_temperature <= '0;
			sample_ch.raw_pressure <= '0;
			gap_cnt <= 0;
		end else if (!sample_ch.valid || sample_ch.ready) begin
			if (gap_cnt != 0) begin
				gap_cnt <= gap_cnt - 1;
				sample_ch.valid <= 1'b0;
			end else if (raw_pending_q.size() != 0 && !quiet && $urandom_range(0, 7) == 0) begin
				gap_cnt <= $urandom_range(0, 7);
				sample_ch.valid <= 1'b0;
			end else if (raw_pending_q.size() != 0) begin
				{sample_ch.raw_temperature, sample_ch.raw_pressure} <= raw_pending_q.pop_front();
				sample_ch.valid <= 1'b1;
			end else begin
				sample_ch.valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure: random bursts plus one long hold on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_cnt <= 0;
		end else if (stall_cnt != 0) begin
			stall_cnt <= stall_cnt - 1;
			result_ch.ready <= 1'b0;
		end else if (long_served != long_asked) begin
			long_served <= long_served + 1;
			stall_cnt <= STALL_LONG - 1;
			result_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_cnt <= $urandom_range(0, 7);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && sample_ch.valid && sample_ch.ready) begin
			comp_expect_q.push_back(compensate(sample_ch.raw_temperature,
				sample_ch.raw_pressure));
		end
	end

	always @(posedge clk) begin
		comp_word_t w;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (comp_expect_q.size() == 0) begin
				$display("%t: unexpected result word temp=%0d press=%0d oor=%0b", $time,
					result_ch.temperature_centi_c, result_ch.pressure_centi_pa,
					result_ch.out_of_range);
				errors++;
			end else begin
				w = comp_expect_q.pop_front();
				if (result_ch.temperature_centi_c !== w.temp) begin
					$display("%t: temperature expected %0d actual %0d", $time,
						w.temp, result_ch.temperature_centi_c);
					errors++;
				end
				if (result_ch.pressure_centi_pa !== w.press) begin
					$display("%t: pressure expected %0d actual %0d", $time,
						w.press, result_ch.pressure_centi_pa);
					errors++;
				end
				if (result_ch.out_of_range !== w.oor) begin
					$display("%t: out_of_range expected %0b actual %0b", $time,
						w.oor, result_ch.out_of_range);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic drain();
		do begin
			@(posedge clk);
		end while (raw_pending_q.size() != 0 || sample_ch.valid || comp_expect_q.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_cal(logic [CFG_W-1:0] wt, logic [CFG_W-1:0] wa,
			logic [CFG_W-1:0] wb, logic [CFG_W-1:0] wc);
		logic [CFG_W-1:0] words [4];
		words = '{wt, wa, wb, wc};
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= cfg_index_t'(i);
			cfg_wdata <= words[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		cal_shadow[CFG_TEMP] = wt & 48'hff_ffff_ffff;
		cal_shadow[CFG_PRESS_A] = wa;
		cal_shadow[CFG_PRESS_B] = wb;
		cal_shadow[CFG_PRESS_C] = wc & 48'hffff_ffff;
	endtask

	task automatic queue_extremes();
		logic [RAW_W-1:0] vals [4];
		vals = '{24'h000000, 24'hffffff, 24'h800000, 24'h7fffff};
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				raw_pending_q.push_back({vals[i], vals[j]});
			end
		end
	endtask

	task automatic queue_random(int n);
		logic [RAW_W-1:0] rt;
		logic [RAW_W-1:0] rp;
		longint centre;
		for (int i = 0; i < n; i++) begin
			centre = longint'({48'd0, cal_shadow[CFG_TEMP][15:0]}) * 256 +
				$urandom_range(0, 1 << 20) - (1 << 19);
			if ($urandom_range(0, 1) == 0 || centre < 0 || centre > 24'hffffff) begin
				rt = RAW_W'($urandom());
			end else begin
				rt = centre[RAW_W-1:0];
			end
			rp = RAW_W'($urandom());
			raw_pending_q.push_back({rt, rp});
		end
	endtask

	function automatic logic [CFG_W-1:0] rand_word();
		return CFG_W'({$urandom(), $urandom()});
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset calibration (all zero).
		queue_extremes();
		queue_random(100);
		drain();

		write_cal({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
		queue_extremes();
		queue_random(100);
		drain();

		// Typical part calibration, with a long hold on the result side.
		write_cal(48'h00f9_4a00_6a00, 48'h0403_f800_3e80, 48'hf2_0a_5800_2f00,
			48'h0012_fc08_1500);
		long_asked++;
		queue_random(150);
		drain();

		write_cal(rand_word(), rand_word(), rand_word(), rand_word());
		queue_random(70);
		drain();
		queue_random(70);
		drain();

		write_cal(48'h0080_0000_0000, 48'h8080_8000_8000, 48'h8080_0000_0000,
			48'h0000_8080_8000);
		queue_extremes();
		queue_random(100);
		drain();

		write_cal(rand_word(), rand_word(), rand_word(), rand_word());
		queue_random(130);
		drain();

		quiet = 1'b1;
		write_cal(48'h00f9_4a00_6a00, rand_word(), rand_word(), rand_word());
		queue_random(130);
		drain();

		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
